// ===== rtl/core/char_lcd_controller_port_unit_defines.svh =====
// Assertion helpers for the character LCD port unit.
`ifndef CHAR_LCD_CONTROLLER_PORT_UNIT_DEFINES_SVH
`define CHAR_LCD_CONTROLLER_PORT_UNIT_DEFINES_SVH

// Checked only outside reset.
`define CLCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset as well.
`define CLCD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/chlcd_pkg.sv =====
package chlcd_pkg;

    localparam int TEXT_DEPTH  = 128;
    localparam int GLYPH_DEPTH = 64;
    localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // port byte bits
    localparam int PORT_BIT_E  = 1;
    localparam int PORT_BIT_RS = 0;

    // command opcode bits, highest set bit wins
    localparam int CMD_BIT_DDRAM_ADDR = 7;
    localparam int CMD_BIT_CGRAM_ADDR = 6;
    localparam int CMD_BIT_FUNC_SET   = 5;
    localparam int CMD_BIT_SHIFT      = 4;
    localparam int CMD_BIT_DISP_CTRL  = 3;
    localparam int CMD_BIT_ENTRY_MODE = 2;
    localparam int CMD_BIT_HOME       = 1;
    localparam int CMD_BIT_CLEAR      = 0;

    // function set: DL bit selects 8-bit interface
    localparam int FUNC_BIT_DL = 4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [4:0] FUNC_RESET = 5'h10;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_READ  = 3'b100
    } t_state;

    // result item, first field highest
    typedef struct packed {
        logic [5:0]          pad;
        logic                nibble_phase;
        logic                writes_to_glyphs;
        logic [GLYPH_AW-1:0] glyph_address;
        logic [TEXT_AW-1:0]  text_address;
        logic [1:0]          entry_mode;
        logic [2:0]          display_control;
        logic [4:0]          function_bits;
        logic                four_bit_mode;
        logic [7:0]          read_char;
    } t_result;

endpackage

// ===== rtl/core/char_lcd_controller_port_unit.sv =====
// Channel      | Dir | Handshake               | Payload
// -------------+-----+-------------------------+--------------------------------------
// input item   | in  | i_s_tvalid / o_s_tready | tuser: kind; tdata: port_byte, read_address
// result item  | out | o_m_tvalid / i_m_tready | tdata: read_char .. nibble_phase
//
// A port write item is decoded in its accept cycle; its result is valid the next cycle.
// A display read item passes through the text RAM read register, then the result register.
// Reset and the clear command run a fill of all 128 text RAM entries with spaces, one
// entry per cycle, while o_s_tready stays low. Reset is synchronous, active low.
// The output register lets a new item in during the cycle a pending result is taken;
// a stalled sink holds o_s_tready low.
module char_lcd_controller_port_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [chlcd_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [7:0] port_byte,
                                                          // [14:8] read_address, [15] zero
    input  logic [0:0]                       i_s_tuser,   // [0] kind
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [chlcd_pkg::OUT_DATA_W-1:0] o_m_tdata    // [7:0] read_char,
                                     // [8] four_bit_mode,
                                     // [13:9] function_bits, [16:14] display_control,
                                     // [18:17] entry_mode, [25:19] text_address,
                                     // [31:26] glyph_address, [32] writes_to_glyphs,
                                     // [33] nibble_phase, [39:34] zero
);

    localparam int AW = chlcd_pkg::TEXT_AW;
    localparam int GW = chlcd_pkg::GLYPH_AW;

    // text RAM, one write and one registered read port
    logic [7:0] mem_text [chlcd_pkg::TEXT_DEPTH];
    logic [7:0] r_rd_data;

    chlcd_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_sweep_idx, n_sweep_idx;

    // controller registers
    logic [AW-1:0] r_text_ptr, n_text_ptr;
    logic [GW-1:0] r_glyph_ptr, n_glyph_ptr;
    logic          r_to_glyph, n_to_glyph;
    logic [4:0]    r_func, n_func;
    logic [2:0]    r_disp, n_disp;
    logic [1:0]    r_entry, n_entry;
    logic [7:0]    r_prev, n_prev;
    logic          r_phase, n_phase;
    logic [3:0]    r_held, n_held;

    logic                r_out_valid, n_out_valid;
    chlcd_pkg::t_result  r_out, n_out;

    logic          s_acc, m_take, is_read;
    logic [7:0]    in_port;
    logic [AW-1:0] in_raddr;
    logic          rise, eight_bit, do_op;
    logic [7:0]    op_byte;
    logic          start_clear;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    assign in_port  = i_s_tdata[7:0];
    assign in_raddr = i_s_tdata[8 +: AW];
    assign is_read  = i_s_tuser[0];

    assign o_s_tready = (r_state == chlcd_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_take     = r_out_valid && i_m_tready;

    // E rising edge against the last written port byte
    assign rise      = in_port[chlcd_pkg::PORT_BIT_E] && !r_prev[chlcd_pkg::PORT_BIT_E];
    assign eight_bit = r_func[chlcd_pkg::FUNC_BIT_DL];
    // in 4-bit mode only the second nibble completes a byte
    assign do_op     = rise && (eight_bit || r_phase);
    assign op_byte   = eight_bit ? in_port : {r_held, in_port[7:4]};

    always_comb begin
        n_text_ptr  = r_text_ptr;
        n_glyph_ptr = r_glyph_ptr;
        n_to_glyph  = r_to_glyph;
        n_func      = r_func;
        n_disp      = r_disp;
        n_entry     = r_entry;
        n_prev      = r_prev;
        n_phase     = r_phase;
        n_held      = r_held;
        start_clear = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_text_ptr;
        mem_wd      = op_byte;

        if (s_acc && !is_read) begin
            n_prev = in_port;
            if (rise && !eight_bit) begin
                n_phase = ~r_phase;
                if (!r_phase) begin
                    n_held = in_port[7:4];
                end
            end
            if (do_op) begin
                if (in_port[chlcd_pkg::PORT_BIT_RS]) begin
                    // data write, wrapping auto-increment
                    if (r_to_glyph) begin
                        // glyph RAM contents only feed the font path, which is not here
                        n_glyph_ptr = r_glyph_ptr + GW'(1);
                    end else begin
                        mem_we     = 1'b1;
                        n_text_ptr = r_text_ptr + AW'(1);
                    end
                end else if (op_byte[chlcd_pkg::CMD_BIT_DDRAM_ADDR]) begin
                    n_text_ptr = op_byte[AW-1:0];
                    n_to_glyph = 1'b0;
                end else if (op_byte[chlcd_pkg::CMD_BIT_CGRAM_ADDR]) begin
                    n_glyph_ptr = op_byte[GW-1:0];
                    n_to_glyph  = 1'b1;
                end else if (op_byte[chlcd_pkg::CMD_BIT_FUNC_SET]) begin
                    n_func  = op_byte[4:0];
                    n_phase = 1'b0;
                end else if (op_byte[chlcd_pkg::CMD_BIT_SHIFT]) begin
                    n_func = r_func;    // cursor/display shift is ignored
                end else if (op_byte[chlcd_pkg::CMD_BIT_DISP_CTRL]) begin
                    n_disp = op_byte[2:0];
                end else if (op_byte[chlcd_pkg::CMD_BIT_ENTRY_MODE]) begin
                    n_entry = op_byte[1:0];
                end else if (op_byte[chlcd_pkg::CMD_BIT_HOME]) begin
                    n_text_ptr = '0;
                    n_to_glyph = 1'b0;
                end else if (op_byte[chlcd_pkg::CMD_BIT_CLEAR]) begin
                    n_text_ptr  = '0;
                    n_to_glyph  = 1'b0;
                    start_clear = 1'b1;
                end
            end
        end

        // fill sweep owns the write port while it runs
        if (r_state == chlcd_pkg::S_SWEEP) begin
            mem_we = 1'b1;
            mem_wa = r_sweep_idx;
            mem_wd = chlcd_pkg::CHAR_SPACE;
        end
    end

    // state machine and result register
    always_comb begin
        n_state     = r_state;
        n_sweep_idx = r_sweep_idx;
        n_out_valid = r_out_valid && !m_take;
        n_out       = r_out;

        case (r_state)
            chlcd_pkg::S_SWEEP: begin
                n_sweep_idx = r_sweep_idx + AW'(1);
                if (r_sweep_idx == AW'(chlcd_pkg::TEXT_DEPTH - 1)) begin
                    n_state = chlcd_pkg::S_IDLE;
                end
            end
            chlcd_pkg::S_IDLE: begin
                if (s_acc && is_read) begin
                    n_state = chlcd_pkg::S_READ;
                end else if (s_acc) begin
                    n_out_valid = 1'b1;
                    n_out       = '{
                        pad:              '0,
                        nibble_phase:     n_phase,
                        writes_to_glyphs: n_to_glyph,
                        glyph_address:    n_glyph_ptr,
                        text_address:     n_text_ptr,
                        entry_mode:       n_entry,
                        display_control:  n_disp,
                        function_bits:    n_func,
                        four_bit_mode:    !n_func[chlcd_pkg::FUNC_BIT_DL],
                        read_char:        '0
                    };
                    if (start_clear) begin
                        n_state     = chlcd_pkg::S_SWEEP;
                        n_sweep_idx = '0;
                    end
                end
            end
            chlcd_pkg::S_READ: begin
                // output slot was freed when the read item went in
                n_state     = chlcd_pkg::S_IDLE;
                n_out_valid = 1'b1;
                n_out       = '{
                    pad:              '0,
                    nibble_phase:     r_phase,
                    writes_to_glyphs: r_to_glyph,
                    glyph_address:    r_glyph_ptr,
                    text_address:     r_text_ptr,
                    entry_mode:       r_entry,
                    display_control:  r_disp,
                    function_bits:    r_func,
                    four_bit_mode:    !r_func[chlcd_pkg::FUNC_BIT_DL],
                    read_char:        r_rd_data
                };
            end
            default: begin
                n_state = chlcd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_text[mem_wa] <= mem_wd;
        end
        if (s_acc && is_read) begin
            r_rd_data <= mem_text[in_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chlcd_pkg::S_SWEEP;
            r_sweep_idx <= '0;
            r_text_ptr  <= '0;
            r_glyph_ptr <= '0;
            r_to_glyph  <= 1'b0;
            r_func      <= chlcd_pkg::FUNC_RESET;
            r_disp      <= '0;
            r_entry     <= '0;
            r_prev      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_idx <= n_sweep_idx;
            r_text_ptr  <= n_text_ptr;
            r_glyph_ptr <= n_glyph_ptr;
            r_to_glyph  <= n_to_glyph;
            r_func      <= n_func;
            r_disp      <= n_disp;
            r_entry     <= n_entry;
            r_prev      <= n_prev;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_out  <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

`include "char_lcd_controller_port_unit_defines.svh"

    `CLCD_ASSERT_RST(a_sweep_after_reset, !i_rst_n |=> !o_s_tready, "input taken during fill")
    `CLCD_ASSERT(a_write_result, (s_acc && !is_read) |=> o_m_tvalid, "write result missing")
    `CLCD_ASSERT(a_read_result, (s_acc && is_read) |-> ##2 o_m_tvalid, "read result missing")
    `CLCD_ASSERT(a_phase_mode, r_phase |-> !r_func[chlcd_pkg::FUNC_BIT_DL], "phase in 8-bit mode")

endmodule
